[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/pcp_pkg.sv]
// Types and constants of the pulse channel programmer.
package pcp_pkg;

    localparam logic ACT_DUTY = 1'b0;
    localparam logic ACT_CFG  = 1'b1;

    localparam logic [15:0] FREQ_LOW_MAX = 16'd4;
    localparam logic [15:0] FREQ_MAX     = 16'd4882;
    localparam logic [15:0] BAND_18_MAX  = 16'd305;
    localparam logic [15:0] BAND_17_MAX  = 16'd610;
    localparam logic [15:0] BAND_16_MAX  = 16'd1220;
    localparam logic [15:0] BAND_15_MAX  = 16'd2441;

    localparam logic [4:0] RES_18 = 5'd18;
    localparam logic [4:0] RES_17 = 5'd17;
    localparam logic [4:0] RES_16 = 5'd16;
    localparam logic [4:0] RES_15 = 5'd15;
    localparam logic [4:0] RES_14 = 5'd14;

    // Period limit: floor(500000/hz) <= us  <=>  hz*us + hz > 500000
    localparam logic [32:0] WIDTH_LIMIT = 33'd500000;

    // x/15 = (x * ceil(2^25/15)) >> 25, exact for x < 2^21
    localparam logic [21:0] RECIP_15    = 22'd2236963;
    localparam int          RECIP_SHIFT = 25;

    typedef struct packed {
        logic [3:0]  channel;
        logic [15:0] freq_hz;
        logic [15:0] width_us;
    } in_item_t;

    typedef struct packed {
        logic        action;
        logic [3:0]  out_channel;
        logic [17:0] duty_count;
        logic [12:0] timer_freq;
        logic [4:0]  resolution_bits;
        logic        last_action;
    } out_item_t;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] width;
        logic [4:0]  res;
    } entry_t;

    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        entry_t     data;
    } mem_wr_t;

    typedef struct packed {
        logic [4:0]  res;
        logic        too_wide;
        logic [17:0] duty;
    } calc_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PLAN_NONE,
        PLAN_LOW,
        PLAN_RISE,
        PLAN_FALL,
        PLAN_WIDTH
    } plan_t;

    function automatic logic [1:0] plan_count(input plan_t plan);
        logic [1:0] n;
        unique case (plan)
            PLAN_LOW:   n = 2'd1;
            PLAN_RISE:  n = 2'd2;
            PLAN_FALL:  n = 2'd3;
            PLAN_WIDTH: n = 2'd1;
            default:    n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic plan_action(input plan_t plan, input logic [1:0] idx);
        logic act;
        unique case (plan)
            PLAN_RISE: act = (idx == 2'd0) ? ACT_CFG : ACT_DUTY;
            PLAN_FALL: act = (idx == 2'd1) ? ACT_CFG : ACT_DUTY;
            default:   act = ACT_DUTY;
        endcase
        return act;
    endfunction

endpackage

[rtl/pcp_state_mem.sv]
// Per-channel state memory: synchronous read, one write port, valid bits.
module pcp_state_mem #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [3:0]      rd_addr,
    output pcp_pkg::entry_t rd_entry,
    input  pcp_pkg::mem_wr_t wr
);
    import pcp_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    entry_t                    mem_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]   valid_reg;
    entry_t                    rd_data_reg;
    logic                      rd_valid_reg;

    always_ff @(posedge clk) begin
        if (wr.en) begin
            mem_reg[wr.addr[IDX_W-1:0]] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr[IDX_W-1:0]];
        end
    end

    // Entries never written read as zero.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr[IDX_W-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr[IDX_W-1:0]];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

[rtl/pcp_calc.sv]
// Arithmetic pipeline: band, width check and duty count.
module pcp_calc (
    input  logic               clk,
    input  logic [15:0]        freq_hz,
    input  logic [15:0]        width_us,
    output pcp_pkg::calc_res_t result
);
    import pcp_pkg::*;

    logic [31:0] prod_reg;
    logic [31:0] prod_next;
    logic        too_wide_reg;
    logic        too_wide_next;
    logic [42:0] quot_reg;
    logic [42:0] quot_next;
    logic [4:0]  res;
    logic [32:0] prod_sum;
    logic [33:0] prod_ext;
    logic [33:0] scaled_full;
    logic [20:0] scaled;

    always_comb begin
        priority if (freq_hz <= BAND_18_MAX) res = RES_18;
        else if (freq_hz <= BAND_17_MAX)     res = RES_17;
        else if (freq_hz <= BAND_16_MAX)     res = RES_16;
        else if (freq_hz <= BAND_15_MAX)     res = RES_15;
        else                                 res = RES_14;
    end

    always_comb begin
        prod_next     = 32'(freq_hz) * 32'(width_us);
        prod_sum      = {1'b0, prod_reg} + {17'd0, freq_hz};
        too_wide_next = (prod_sum > WIDTH_LIMIT);
        prod_ext      = {2'b00, prod_reg};
        // scale by 2^(res-16); when the width fits, the result is below 2^21
        unique case (res)
            RES_18:  scaled_full = prod_ext << 2;
            RES_17:  scaled_full = prod_ext << 1;
            RES_16:  scaled_full = prod_ext;
            RES_15:  scaled_full = prod_ext >> 1;
            default: scaled_full = prod_ext >> 2;
        endcase
        scaled    = scaled_full[20:0];
        quot_next = 43'(scaled) * 43'(RECIP_15);
    end

    always_ff @(posedge clk) begin
        prod_reg     <= prod_next;
        too_wide_reg <= too_wide_next;
        quot_reg     <= quot_next;
    end

    assign result.res      = res;
    assign result.too_wide = too_wide_reg;
    assign result.duty     = quot_reg[RECIP_SHIFT +: 18];

endmodule

[rtl/pulse_channel_programmer_top.sv]
// Top level of the pulse channel programmer: control sequencer and result register.
//
// Usage
//   in_valid/in_ready/in_item carry one request: channel, freq_hz, width_us.
//   out_valid/out_ready/out_item carry the timer actions it causes, zero to
//   three per request, in order; last_action marks the final one.
//   in_ready is high only while the sequencer is idle, so requests are
//   handled one at a time.
// Timing
//   A request is read from the per-channel state memory on the cycle it is
//   accepted, then passes through ST_MUL (product multiplier), ST_DIV
//   (reciprocal multiplier, divide by 15) and ST_DECIDE (deciding and writing back).
//   The first action is registered in ST_EMIT, the next ones one per cycle
//   while out_ready does not stall them; a request causes 0 to 3 actions.
//   The memory read-modify-write is the pacing loop.
// Reset
//   Per-channel valid bits clear, so every channel starts with zero stored
//   frequency, width and resolution; no clearing pass is needed.
// Backpressure
//   The output register holds an action while out_ready is low and the
//   sequencer waits; the last action may still sit there while the next
//   request is accepted.
module pulse_channel_programmer_top #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pcp_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output pcp_pkg::out_item_t out_item
);
    import pcp_pkg::*;

    state_t    state_reg;
    state_t    state_next;
    plan_t     plan_reg;
    plan_t     plan_next;
    plan_t     plan_c;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic      in_range_reg;
    in_item_t  req_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    logic      accept;
    entry_t    prev;
    mem_wr_t   wr;
    calc_res_t calc;
    logic      act;
    logic      last;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    pcp_state_mem #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (in_item.channel),
        .rd_entry (prev),
        .wr       (wr)
    );

    pcp_calc u_calc (
        .clk      (clk),
        .freq_hz  (req_reg.freq_hz),
        .width_us (req_reg.width_us),
        .result   (calc)
    );

    // Decide the action list and the write-back from the stored entry.
    always_comb begin
        plan_c       = PLAN_NONE;
        wr.en        = 1'b0;
        wr.addr      = req_reg.channel;
        wr.data.freq = req_reg.freq_hz;
        wr.data.width = req_reg.width_us;
        wr.data.res  = calc.res;
        priority if (!in_range_reg) begin
            plan_c = PLAN_NONE;
        end else if (req_reg.freq_hz <= FREQ_LOW_MAX) begin
            // near-DC request: duty zero, only the frequency is kept
            plan_c        = PLAN_LOW;
            wr.en         = 1'b1;
            wr.data.width = prev.width;
            wr.data.res   = prev.res;
        end else if (req_reg.freq_hz > FREQ_MAX || calc.too_wide) begin
            plan_c = PLAN_NONE;
        end else begin
            wr.en = 1'b1;
            priority if (prev.freq < req_reg.freq_hz) begin
                plan_c = PLAN_RISE;
            end else if (prev.freq > req_reg.freq_hz || prev.res > calc.res) begin
                plan_c = PLAN_FALL;
            end else if (prev.width != req_reg.width_us && prev.res == calc.res) begin
                plan_c = PLAN_WIDTH;
            end else begin
                plan_c = PLAN_NONE;
            end
        end
        if (state_reg != ST_DECIDE) begin
            wr.en = 1'b0;
        end
    end

    // Current action of the list.
    always_comb begin
        act  = plan_action(plan_reg, idx_reg);
        last = (idx_reg == 2'(plan_count(plan_reg) - 2'd1));
        out_item_next.action          = act;
        out_item_next.out_channel     = req_reg.channel;
        out_item_next.duty_count      = (act == ACT_DUTY && plan_reg != PLAN_LOW)
                                        ? calc.duty : 18'd0;
        out_item_next.timer_freq      = (act == ACT_CFG) ? req_reg.freq_hz[12:0] : 13'd0;
        out_item_next.resolution_bits = (act == ACT_CFG) ? calc.res : 5'd0;
        out_item_next.last_action     = last;
    end

    always_comb begin
        state_next     = state_reg;
        plan_next      = plan_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                plan_next  = plan_c;
                idx_next   = 2'd0;
                state_next = (plan_count(plan_c) != 2'd0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + 2'd1;
                    if (last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            plan_reg      <= PLAN_NONE;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            plan_reg      <= plan_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            req_reg      <= in_item;
            in_range_reg <= ({1'b0, in_item.channel} < 5'(NUM_CHANNELS));
        end
        if (state_reg == ST_EMIT && (!out_valid_reg || out_ready)) begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[rtl/pcp_checker.sv]
// Port-level checker of the pulse channel programmer, bound to the top level.
`include "assert_macros.svh"

module pcp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input pcp_pkg::out_item_t out_item
);
    import pcp_pkg::*;

    logic cfg_beat;
    logic duty_beat;
    logic cfg_fields_zero;
    logic res_in_range;

    assign cfg_beat        = out_valid && (out_item.action == ACT_CFG);
    assign duty_beat       = out_valid && (out_item.action == ACT_DUTY);
    assign cfg_fields_zero = (out_item.timer_freq == 13'd0) &&
                             (out_item.resolution_bits == 5'd0);
    assign res_in_range    = (out_item.resolution_bits >= RES_14) &&
                             (out_item.resolution_bits <= RES_18);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_item))
    `ASSERT_IMPLY(a_cfg_no_duty, cfg_beat, out_item.duty_count == 18'd0)
    `ASSERT_IMPLY(a_duty_no_cfg, duty_beat, cfg_fields_zero)
    `ASSERT_IMPLY(a_cfg_res, cfg_beat, res_in_range)

endmodule

bind pulse_channel_programmer_top pcp_checker u_pcp_checker (.*);

[test/tb_pulse_channel_programmer_top.sv]
// Self-checking testbench for the pulse channel programmer: directed and random requests.
module tb_pulse_channel_programmer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcp_pkg::*;

    // Half of one second in microseconds; a width at or past this/hz is too long.
    localparam int unsigned HALF_SECOND_US = 500000;
    // Cycles without any accepted item before the run is declared hung.
    localparam int unsigned HANG_LIMIT = 500;
    // Settling time after the last expected action: room for the pipeline
    // plus up to 3 actions, with margin.
    localparam int unsigned SETTLE_CYCLES = 16;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    // Per-channel copy of what the block remembers.
    logic [15:0] chan_freq  [16];
    logic [15:0] chan_width [16];
    logic [4:0]  chan_res   [16];

    // Timer actions still owed by the block, oldest first.
    out_item_t pending_actions[$];

    int unsigned mismatches = 0;
    // Cleared for the last part of the run, where neither side idles.
    bit          idling_on = 1'b1;

    pulse_channel_programmer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Expected behavior
    // ------------------------------------------------------------------

    function automatic out_item_t make_action(input logic act, input logic [3:0] ch,
                                              input logic [17:0] duty,
                                              input logic [12:0] tfreq,
                                              input logic [4:0] res);
        out_item_t a;
        a.action          = act;
        a.out_channel     = ch;
        a.duty_count      = duty;
        a.timer_freq      = tfreq;
        a.resolution_bits = res;
        a.last_action     = 1'b0;
        return a;
    endfunction

    // Works out the actions one accepted request causes and updates the
    // per-channel memory the same way the block does.
    function automatic void predict_actions(input in_item_t req);
        logic [3:0]  ch;
        logic [15:0] hz;
        logic [15:0] us;
        logic [4:0]  res;
        logic [63:0] prod;
        logic [63:0] quot;
        logic [17:0] duty;
        out_item_t   acts[$];

        ch = req.channel;
        hz = req.freq_hz;
        us = req.width_us;

        // Very low frequency: a single zero duty write, only the frequency is kept.
        if (hz <= FREQ_LOW_MAX)
        begin
            acts.push_back(make_action(ACT_DUTY, ch, '0, '0, '0));
            acts[0].last_action = 1'b1;
            pending_actions.push_back(acts[0]);
            chan_freq[ch] = hz;
            return;
        end

        if (hz > FREQ_MAX)
            return;
        else if (hz <= BAND_18_MAX)
            res = RES_18;
        else if (hz <= BAND_17_MAX)
            res = RES_17;
        else if (hz <= BAND_16_MAX)
            res = RES_16;
        else if (hz <= BAND_15_MAX)
            res = RES_15;
        else
            res = RES_14;

        // Pulse as wide as half the period or more: dropped, memory untouched.
        if ((HALF_SECOND_US / 32'(hz)) <= 32'(us))
            return;

        prod = 64'(hz) * 64'(us);
        if (res >= RES_16)
            quot = (prod << (res - RES_16)) / 64'd15;
        else
            quot = prod / (64'd15 << (RES_16 - res));
        duty = quot[17:0];

        if (chan_freq[ch] < hz)
        begin
            acts.push_back(make_action(ACT_CFG, ch, '0, hz[12:0], res));
            acts.push_back(make_action(ACT_DUTY, ch, duty, '0, '0));
        end
        else if (chan_freq[ch] > hz || chan_res[ch] > res)
        begin
            // Drop the duty first so the new period never sees the old count.
            acts.push_back(make_action(ACT_DUTY, ch, duty, '0, '0));
            acts.push_back(make_action(ACT_CFG, ch, '0, hz[12:0], res));
            acts.push_back(make_action(ACT_DUTY, ch, duty, '0, '0));
        end
        else if (chan_width[ch] != us && chan_freq[ch] == hz && chan_res[ch] == res)
        begin
            acts.push_back(make_action(ACT_DUTY, ch, duty, '0, '0));
        end

        if (acts.size() > 0)
            acts[acts.size() - 1].last_action = 1'b1;
        foreach (acts[i])
            pending_actions.push_back(acts[i]);

        chan_freq[ch]  = hz;
        chan_width[ch] = us;
        chan_res[ch]   = res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every action leaving the block is matched against
    // the oldest one still owed.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_actions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected action %p", $realtime, out_item);
            end
            else
            begin
                want = pending_actions.pop_front();
                if (out_item.action !== want.action ||
                    out_item.out_channel !== want.out_channel ||
                    out_item.duty_count !== want.duty_count ||
                    out_item.timer_freq !== want.timer_freq ||
                    out_item.resolution_bits !== want.resolution_bits ||
                    out_item.last_action !== want.last_action)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: action mismatch\n  expected %p\n  actual   %p",
                                 $realtime, want, out_item);
                end
            end
        end
    end

    // Hang detection: count cycles in which neither channel moves an item.
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $realtime, HANG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: ready runs broken by stall bursts; ready stays high once idling is off.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                if (idling_on)
                    repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic in_item_t make_request(input logic [3:0] ch, input logic [15:0] hz,
                                              input logic [15:0] us);
        in_item_t req;
        req.channel  = ch;
        req.freq_hz  = hz;
        req.width_us = us;
        return req;
    endfunction

    // Drives one request; returns right after the edge that accepted it.
    // Valid stays high into the next call unless a gap is taken.
    task automatic send_request(input in_item_t req);
        int unsigned gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        predict_actions(req);
    endtask

    // Holds off new requests until every owed action has come out,
    // then lets the pipeline settle.
    task automatic wait_actions_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Well-formed request: frequency inside the bands, mostly a legal width,
    // often reusing the channel's stored frequency or width.
    function automatic in_item_t random_request();
        in_item_t    req;
        int unsigned limit;
        int unsigned pick;
        logic [15:0] edges[10];

        edges = '{16'd5, 16'd305, 16'd306, 16'd610, 16'd611,
                  16'd1220, 16'd1221, 16'd2441, 16'd2442, 16'd4882};
        req.channel = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 9);
        if (pick < 3 && chan_freq[req.channel] > FREQ_LOW_MAX &&
            chan_freq[req.channel] <= FREQ_MAX)
            req.freq_hz = chan_freq[req.channel];
        else if (pick == 3)
            req.freq_hz = 16'($urandom_range(0, FREQ_LOW_MAX));
        else
        begin
            case ($urandom_range(0, 5))
                0: req.freq_hz = 16'($urandom_range(5, BAND_18_MAX));
                1: req.freq_hz = 16'($urandom_range(BAND_18_MAX + 1, BAND_17_MAX));
                2: req.freq_hz = 16'($urandom_range(BAND_17_MAX + 1, BAND_16_MAX));
                3: req.freq_hz = 16'($urandom_range(BAND_16_MAX + 1, BAND_15_MAX));
                4: req.freq_hz = 16'($urandom_range(BAND_15_MAX + 1, FREQ_MAX));
                default: req.freq_hz = edges[$urandom_range(0, 9)];
            endcase
        end

        if (req.freq_hz <= FREQ_LOW_MAX)
            req.width_us = 16'($urandom);
        else
        begin
            limit = HALF_SECOND_US / req.freq_hz;
            pick  = $urandom_range(0, 19);
            if (pick < 3 && limit <= 65535)
                req.width_us = 16'(limit - 1);
            else if (pick == 3 && limit <= 65535)
                req.width_us = 16'(limit);          // just too wide
            else if (pick < 7)
                req.width_us = chan_width[req.channel];
            else
                req.width_us = 16'($urandom_range(0, (limit > 65536) ? 65535 : limit - 1));
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero duty writes at the lowest frequencies, then a climb back out of them.
    task automatic test_low_frequency();
        send_request(make_request(4'd0, 16'd0, 16'd0));
        send_request(make_request(4'd0, 16'd4, 16'hFFFF));
        send_request(make_request(4'd0, 16'd3, 16'd1));
        send_request(make_request(4'd4, 16'd5, 16'd10));
        send_request(make_request(4'd4, 16'd0, 16'd7));
        send_request(make_request(4'd4, 16'd5, 16'd10));     // stored 0, so it climbs again
    endtask

    // Climbs through every band edge, drops back, then frequencies out of range.
    task automatic test_band_edges();
        send_request(make_request(4'd2, BAND_18_MAX, 16'd1));
        send_request(make_request(4'd2, BAND_18_MAX + 16'd1, 16'd1));
        send_request(make_request(4'd2, BAND_17_MAX, 16'd1));
        send_request(make_request(4'd2, BAND_17_MAX + 16'd1, 16'd1));
        send_request(make_request(4'd2, BAND_16_MAX, 16'd1));
        send_request(make_request(4'd2, BAND_16_MAX + 16'd1, 16'd1));
        send_request(make_request(4'd2, BAND_15_MAX, 16'd1));
        send_request(make_request(4'd2, BAND_15_MAX + 16'd1, 16'd1));
        send_request(make_request(4'd2, FREQ_MAX, 16'd101));
        send_request(make_request(4'd2, BAND_18_MAX, 16'd1638)); // falling: three actions
        send_request(make_request(4'd2, FREQ_MAX + 16'd1, 16'd0));
        send_request(make_request(4'd2, 16'hFFFF, 16'hFFFF));
    endtask

    // Width at the limit, width-only change, unchanged request, widest legal pulse.
    task automatic test_width_limit();
        send_request(make_request(4'd5, BAND_18_MAX, 16'd1639));
        send_request(make_request(4'd5, BAND_18_MAX, 16'd1638));
        send_request(make_request(4'd5, BAND_18_MAX, 16'd1000));
        send_request(make_request(4'd5, BAND_18_MAX, 16'd1000));
        send_request(make_request(4'd5, FREQ_MAX, 16'd102));
        send_request(make_request(4'd15, 16'd5, 16'hFFFF));
    endtask

    // Mostly well-formed traffic; every so often the sender waits for the
    // block to catch up completely.
    task automatic test_random_traffic(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            send_request(random_request());
            if (i % 60 == 59)
                wait_actions_drained();
        end
    endtask

    // Unconstrained fields: mostly out-of-band frequencies and overlong widths.
    task automatic test_noise(input int unsigned count);
        in_item_t req;
        for (int unsigned i = 0; i < count; i++)
        begin
            req = in_item_t'({$urandom, $urandom});
            if (i % 4 == 0)
                req.freq_hz = 16'($urandom_range(0, FREQ_MAX));
            send_request(req);
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_back_to_back(input int unsigned count);
        idling_on = 1'b0;
        for (int unsigned i = 0; i < count; i++)
            send_request(random_request());
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        foreach (chan_freq[i])
        begin
            chan_freq[i]  = '0;
            chan_width[i] = '0;
            chan_res[i]   = '0;
        end
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_low_frequency();
        test_band_edges();
        test_width_limit();
        wait_actions_drained();
        test_random_traffic(250);
        test_noise(60);
        test_back_to_back(80);
        wait_actions_drained();

        if (mismatches == 0 && pending_actions.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
